// ----- hdl/rmc_pkg.sv -----
// Shared types and constants for the NMEA RMC position parser.
// Used by rmc_parse, rmc_conv and nmea_rmc_position_parser; depends on nothing.
package rmc_pkg;

    localparam int MAX_LINE_DEF = 128;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_V      = 8'h56;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_W      = 8'h57;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Field numbers counted in commas after the header.
    localparam logic [2:0] FLD_VALID = 3'd2;
    localparam logic [2:0] FLD_LAT   = 3'd3;
    localparam logic [2:0] FLD_NS    = 3'd4;
    localparam logic [2:0] FLD_LON   = 3'd5;
    localparam logic [2:0] FLD_EW    = 3'd6;
    localparam logic [2:0] FLD_LAST  = 3'd7;

    localparam logic [3:0] LAT_DEG_DIGITS = 4'd2;
    localparam logic [3:0] LON_DEG_DIGITS = 4'd3;

    localparam int LAT_DEG_W = 7;
    localparam int LON_DEG_W = 10;
    localparam int MIN_W     = 20;
    localparam int LAT_W     = 31;
    localparam int LON_W     = 35;
    localparam int MIN50_W   = 26;
    localparam int FRAC_W    = 24;

    localparam logic [23:0] DEG_SCALE = 24'd10000000;
    // Reciprocal of 3 scaled by 2^33; exact for any 32-bit dividend.
    localparam logic [31:0] RECIP3    = 32'hAAAAAAAB;
    localparam int          RECIP3_SH = 33;

    localparam int TDATA_W = 88;

    typedef struct packed {
        logic                 fix_valid;
        logic [LAT_DEG_W-1:0] lat_deg;
        logic [MIN_W-1:0]     lat_min;
        logic [LON_DEG_W-1:0] lon_deg;
        logic [MIN_W-1:0]     lon_min;
        logic [7:0]           north_south;
        logic [7:0]           east_west;
        logic                 digit_error;
    } rmc_snap_t;

    typedef struct packed {
        logic       to_deg;
        logic       to_min;
        logic [3:0] value;
        logic       bad;
    } coord_step_t;

    // One character of a DDMM.MMMM or DDDMM.MMMM field at index pos.
    function automatic coord_step_t coord_step(logic [7:0] c, logic [3:0] pos,
                                               logic [3:0] deg_digits);
        coord_step_t r;
        logic        dig;
        logic        use_it;
        r      = '0;
        dig    = (c >= CH_ZERO) && (c <= CH_NINE);
        use_it = 1'b0;
        if (pos < deg_digits) begin
            r.to_deg = 1'b1;
            use_it   = 1'b1;
        end else if (pos < deg_digits + 4'd2) begin
            r.to_min = 1'b1;
            use_it   = 1'b1;
        end else if (pos == deg_digits + 4'd2) begin
            use_it   = 1'b0;
        end else if (pos < deg_digits + 4'd7) begin
            r.to_min = 1'b1;
            use_it   = 1'b1;
        end
        if (use_it) begin
            r.value = dig ? 4'(c - CH_ZERO) : 4'd0;
            r.bad   = !dig;
        end
        return r;
    endfunction

endpackage

// ----- hdl/rmc_parse.sv -----
// Byte-level sentence tracker: header match, field counting, digit accumulation.
// Depends on rmc_pkg; feeds a snapshot of the line into rmc_conv on each RMC line end.
module rmc_parse #(
    parameter int MAX_LINE = rmc_pkg::MAX_LINE_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        rx_byte,
    output logic              emit,
    output rmc_pkg::rmc_snap_t snap
);

    localparam int POS_W = $clog2(MAX_LINE + 1);

    logic [POS_W-1:0]              pos_reg,     pos_next;
    logic [2:0]                    hdr_reg,     hdr_next;
    logic [2:0]                    fld_reg,     fld_next;
    logic [3:0]                    cif_reg,     cif_next;
    logic [rmc_pkg::LAT_DEG_W-1:0] lat_deg_reg, lat_deg_next;
    logic [rmc_pkg::MIN_W-1:0]     lat_min_reg, lat_min_next;
    logic [rmc_pkg::LON_DEG_W-1:0] lon_deg_reg, lon_deg_next;
    logic [rmc_pkg::MIN_W-1:0]     lon_min_reg, lon_min_next;
    logic [7:0]                    ns_reg,      ns_next;
    logic [7:0]                    ew_reg,      ew_next;
    logic                          valid_reg,   valid_next;
    logic                          bad_reg,     bad_next;

    rmc_pkg::coord_step_t          lat_step;
    rmc_pkg::coord_step_t          lon_step;

    // A '$' clears the field number, so a coordinate step only matters with the stored index.
    assign lat_step = rmc_pkg::coord_step(rx_byte, cif_reg, rmc_pkg::LAT_DEG_DIGITS);
    assign lon_step = rmc_pkg::coord_step(rx_byte, cif_reg, rmc_pkg::LON_DEG_DIGITS);

    always_comb
    begin
        pos_next     = pos_reg;
        hdr_next     = hdr_reg;
        fld_next     = fld_reg;
        cif_next     = cif_reg;
        lat_deg_next = lat_deg_reg;
        lat_min_next = lat_min_reg;
        lon_deg_next = lon_deg_reg;
        lon_min_next = lon_min_reg;
        ns_next      = ns_reg;
        ew_next      = ew_reg;
        valid_next   = valid_reg;
        bad_next     = bad_reg;
        emit         = 1'b0;
        if (accept)
        begin
            if (rx_byte == rmc_pkg::CH_DOLLAR)
            begin
                pos_next     = '0;
                hdr_next     = '0;
                fld_next     = '0;
                cif_next     = '0;
                lat_deg_next = '0;
                lat_min_next = '0;
                lon_deg_next = '0;
                lon_min_next = '0;
                ns_next      = '0;
                ew_next      = '0;
                bad_next     = 1'b0;
            end
            // A full line ignores everything up to the next '$'.
            if (pos_next != POS_W'(MAX_LINE))
            begin
                if (pos_next == POS_W'(0) && rx_byte == rmc_pkg::CH_DOLLAR)
                    hdr_next[0] = 1'b1;
                if (pos_next == POS_W'(4) && rx_byte == rmc_pkg::CH_M)
                    hdr_next[1] = 1'b1;
                if (pos_next == POS_W'(5) && rx_byte == rmc_pkg::CH_C)
                    hdr_next[2] = 1'b1;
                pos_next = pos_next + POS_W'(1);
                if (hdr_next == 3'b111 && rx_byte == rmc_pkg::CH_LF)
                begin
                    emit         = 1'b1;
                    pos_next     = '0;
                    hdr_next     = '0;
                    fld_next     = '0;
                    cif_next     = '0;
                    lat_deg_next = '0;
                    lat_min_next = '0;
                    lon_deg_next = '0;
                    lon_min_next = '0;
                    ns_next      = '0;
                    ew_next      = '0;
                    bad_next     = 1'b0;
                end
                else if (rx_byte == rmc_pkg::CH_COMMA)
                begin
                    if (fld_next != rmc_pkg::FLD_LAST)
                        fld_next = fld_next + 3'd1;
                    cif_next = '0;
                end
                else
                begin
                    case (fld_next)
                        rmc_pkg::FLD_VALID:
                        begin
                            if (cif_next == 4'd0 && rx_byte == rmc_pkg::CH_A)
                                valid_next = 1'b1;
                            else if (cif_next == 4'd0 && rx_byte == rmc_pkg::CH_V)
                                valid_next = 1'b0;
                        end
                        rmc_pkg::FLD_LAT:
                        begin
                            if (lat_step.to_deg)
                                lat_deg_next = rmc_pkg::LAT_DEG_W'(lat_deg_next * 4'd10
                                               + rmc_pkg::LAT_DEG_W'(lat_step.value));
                            if (lat_step.to_min)
                                lat_min_next = rmc_pkg::MIN_W'(lat_min_next * 4'd10
                                               + rmc_pkg::MIN_W'(lat_step.value));
                            if (lat_step.bad)
                                bad_next = 1'b1;
                        end
                        rmc_pkg::FLD_NS:
                        begin
                            if (cif_next == 4'd0)
                                ns_next = rx_byte;
                        end
                        rmc_pkg::FLD_LON:
                        begin
                            if (lon_step.to_deg)
                                lon_deg_next = rmc_pkg::LON_DEG_W'(lon_deg_next * 4'd10
                                               + rmc_pkg::LON_DEG_W'(lon_step.value));
                            if (lon_step.to_min)
                                lon_min_next = rmc_pkg::MIN_W'(lon_min_next * 4'd10
                                               + rmc_pkg::MIN_W'(lon_step.value));
                            if (lon_step.bad)
                                bad_next = 1'b1;
                        end
                        rmc_pkg::FLD_EW:
                        begin
                            if (cif_next == 4'd0)
                                ew_next = rx_byte;
                        end
                        default:
                        begin
                        end
                    endcase
                    if (cif_next != 4'd15)
                        cif_next = cif_next + 4'd1;
                end
            end
        end
    end

    // A line end never coincides with a '$', so the snapshot is the stored line.
    always_comb
    begin
        snap.fix_valid   = valid_reg;
        snap.lat_deg     = lat_deg_reg;
        snap.lat_min     = lat_min_reg;
        snap.lon_deg     = lon_deg_reg;
        snap.lon_min     = lon_min_reg;
        snap.north_south = ns_reg;
        snap.east_west   = ew_reg;
        snap.digit_error = bad_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            hdr_reg     <= '0;
            fld_reg     <= '0;
            cif_reg     <= '0;
            lat_deg_reg <= '0;
            lat_min_reg <= '0;
            lon_deg_reg <= '0;
            lon_min_reg <= '0;
            ns_reg      <= '0;
            ew_reg      <= '0;
            valid_reg   <= 1'b0;
            bad_reg     <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            hdr_reg     <= hdr_next;
            fld_reg     <= fld_next;
            cif_reg     <= cif_next;
            lat_deg_reg <= lat_deg_next;
            lat_min_reg <= lat_min_next;
            lon_deg_reg <= lon_deg_next;
            lon_min_reg <= lon_min_next;
            ns_reg      <= ns_next;
            ew_reg      <= ew_next;
            valid_reg   <= valid_next;
            bad_reg     <= bad_next;
        end
    end

endmodule

// ----- hdl/rmc_conv.sv -----
// Three-stage conversion of degrees and minutes into signed 1e-7 degree units.
// Depends on rmc_pkg; the last stage is the result register of the block.
module rmc_conv (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  rmc_pkg::rmc_snap_t          snap,
    output logic                        ready,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [rmc_pkg::TDATA_W-1:0] out_data
);

    localparam int LAT_DE7_W = 30;
    localparam int LON_DE7_W = 34;
    localparam int PROD_W    = rmc_pkg::MIN50_W + 32;

    logic v1_reg, v2_reg, v3_reg;
    logic adv1, adv2, adv3;

    // Stage 1: whole degrees scaled, minutes times 50.
    logic [LAT_DE7_W-1:0]        s1_lat_de7_reg;
    logic [LON_DE7_W-1:0]        s1_lon_de7_reg;
    logic [rmc_pkg::MIN50_W-1:0] s1_lat_m50_reg;
    logic [rmc_pkg::MIN50_W-1:0] s1_lon_m50_reg;
    logic                        s1_lat_neg_reg, s1_lon_neg_reg;
    logic [7:0]                  s1_ns_reg, s1_ew_reg;
    logic                        s1_fix_reg, s1_bad_reg;

    // Stage 2: minutes*50/3.
    logic [LAT_DE7_W-1:0]        s2_lat_de7_reg;
    logic [LON_DE7_W-1:0]        s2_lon_de7_reg;
    logic [rmc_pkg::FRAC_W-1:0]  s2_lat_frac_reg;
    logic [rmc_pkg::FRAC_W-1:0]  s2_lon_frac_reg;
    logic                        s2_lat_neg_reg, s2_lon_neg_reg;
    logic [7:0]                  s2_ns_reg, s2_ew_reg;
    logic                        s2_fix_reg, s2_bad_reg;

    // Stage 3: signed result.
    logic [rmc_pkg::LAT_W-1:0]   s3_lat_reg;
    logic [rmc_pkg::LON_W-1:0]   s3_lon_reg;
    logic [7:0]                  s3_ns_reg, s3_ew_reg;
    logic                        s3_fix_reg, s3_bad_reg;

    logic [rmc_pkg::MIN50_W-1:0] lat_m50, lon_m50;
    logic [PROD_W-1:0]           lat_prod, lon_prod;
    logic [rmc_pkg::LAT_W-1:0]   lat_mag;
    logic [rmc_pkg::LON_W-1:0]   lon_mag;

    assign adv3  = !v3_reg || out_ready;
    assign adv2  = !v2_reg || adv3;
    assign adv1  = !v1_reg || adv2;
    assign ready = adv1;

    // x*50 = x*32 + x*16 + x*2
    assign lat_m50 = {1'b0, snap.lat_min, 5'b0} + {2'b0, snap.lat_min, 4'b0}
                   + {5'b0, snap.lat_min, 1'b0};
    assign lon_m50 = {1'b0, snap.lon_min, 5'b0} + {2'b0, snap.lon_min, 4'b0}
                   + {5'b0, snap.lon_min, 1'b0};

    assign lat_prod = PROD_W'(s1_lat_m50_reg) * PROD_W'(rmc_pkg::RECIP3);
    assign lon_prod = PROD_W'(s1_lon_m50_reg) * PROD_W'(rmc_pkg::RECIP3);

    assign lat_mag = rmc_pkg::LAT_W'(s2_lat_de7_reg) + rmc_pkg::LAT_W'(s2_lat_frac_reg);
    assign lon_mag = rmc_pkg::LON_W'(s2_lon_de7_reg) + rmc_pkg::LON_W'(s2_lon_frac_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= load;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && load)
        begin
            s1_lat_de7_reg <= LAT_DE7_W'(snap.lat_deg) * LAT_DE7_W'(rmc_pkg::DEG_SCALE);
            s1_lon_de7_reg <= LON_DE7_W'(snap.lon_deg) * LON_DE7_W'(rmc_pkg::DEG_SCALE);
            s1_lat_m50_reg <= lat_m50;
            s1_lon_m50_reg <= lon_m50;
            s1_lat_neg_reg <= (snap.north_south == rmc_pkg::CH_S);
            s1_lon_neg_reg <= (snap.east_west == rmc_pkg::CH_W);
            s1_ns_reg      <= snap.north_south;
            s1_ew_reg      <= snap.east_west;
            s1_fix_reg     <= snap.fix_valid;
            s1_bad_reg     <= snap.digit_error;
        end
        if (adv2 && v1_reg)
        begin
            s2_lat_de7_reg  <= s1_lat_de7_reg;
            s2_lon_de7_reg  <= s1_lon_de7_reg;
            s2_lat_frac_reg <= lat_prod[rmc_pkg::RECIP3_SH +: rmc_pkg::FRAC_W];
            s2_lon_frac_reg <= lon_prod[rmc_pkg::RECIP3_SH +: rmc_pkg::FRAC_W];
            s2_lat_neg_reg  <= s1_lat_neg_reg;
            s2_lon_neg_reg  <= s1_lon_neg_reg;
            s2_ns_reg       <= s1_ns_reg;
            s2_ew_reg       <= s1_ew_reg;
            s2_fix_reg      <= s1_fix_reg;
            s2_bad_reg      <= s1_bad_reg;
        end
        if (adv3 && v2_reg)
        begin
            s3_lat_reg <= s2_lat_neg_reg ? (~lat_mag + rmc_pkg::LAT_W'(1)) : lat_mag;
            s3_lon_reg <= s2_lon_neg_reg ? (~lon_mag + rmc_pkg::LON_W'(1)) : lon_mag;
            s3_ns_reg  <= s2_ns_reg;
            s3_ew_reg  <= s2_ew_reg;
            s3_fix_reg <= s2_fix_reg;
            s3_bad_reg <= s2_bad_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = {4'b0, s3_bad_reg, s3_ew_reg, s3_ns_reg,
                        s3_lon_reg, s3_lat_reg, s3_fix_reg};

endmodule

// ----- hdl/nmea_rmc_position_parser.sv -----
// Top level of the NMEA RMC position parser: byte tracker plus conversion pipeline.
// Depends on rmc_pkg, rmc_parse and rmc_conv.
//
//  channel   dir  width  contents
//  s_axis    in   8      rx_byte, one received character per transfer
//  m_axis    out  88     one position result per complete RMC line
//
// A transfer can occur in every cycle while s_axis_tready is high.
// After the transfer of the line feed, the snapshot passes through conversion
// stages 1, 2 and 3; m_axis_tvalid rises once stage 3 holds the result, so the
// conversion pipeline sets the latency. All control state clears on rst_n.
// When m_axis stalls, the pipeline fills and s_axis_tready drops once all three
// stages hold a result.
module nmea_rmc_position_parser #(
    parameter int MAX_LINE = rmc_pkg::MAX_LINE_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,  // [7:0] rx_byte
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [0] fix_valid, [31:1] latitude_e7, [66:32] longitude_e7,
    // [74:67] north_south, [82:75] east_west, [83] digit_error, [87:84] zero
    output logic [rmc_pkg::TDATA_W-1:0] m_axis_tdata
);

    logic               accept;
    logic               emit;
    logic               conv_ready;
    rmc_pkg::rmc_snap_t snap;

    assign s_axis_tready = conv_ready;
    assign accept        = s_axis_tvalid && conv_ready;

    rmc_parse #(
        .MAX_LINE (MAX_LINE)
    ) u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (s_axis_tdata),
        .emit    (emit),
        .snap    (snap)
    );

    rmc_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (emit),
        .snap      (snap),
        .ready     (conv_ready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule
